// ===== design/spring_contact_force_jacobian_defines.svh =====
// Assertion helpers for the contact spring block.
`ifndef SPRING_CONTACT_FORCE_JACOBIAN_DEFINES_SVH
`define SPRING_CONTACT_FORCE_JACOBIAN_DEFINES_SVH

// same-cycle implication, sampled on aclk, off during reset
`define SCFJ_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define SCFJ_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/scfj_pkg.sv =====
package scfj_pkg;

    localparam int MAX_NODES    = 65536;
    localparam int DOF_PER_NODE = 4;

    localparam logic [31:0] STIFF_RESET = 32'h0001_0000;

    localparam int SUM_W       = 66;
    localparam int ROOT_W      = 33;
    localparam int SQRT_STAGES = 34;
    localparam int SQ_ACC_W    = 68;
    localparam int DIV_W       = 50;
    localparam int DEN_W       = 33;

    typedef struct packed {
        logic [15:0]        node_index;
        logic signed [31:0] node_x;
        logic signed [31:0] node_y;
        logic signed [31:0] node_z;
        logic signed [31:0] partner_x;
        logic signed [31:0] partner_y;
        logic signed [31:0] partner_z;
        logic [31:0]        rest_length;
        logic               last_contact;
    } in_t;

    typedef struct packed {
        logic [17:0]        dof_base;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic signed [31:0] jac_xx;
        logic signed [31:0] jac_xy;
        logic signed [31:0] jac_xz;
        logic signed [31:0] jac_yy;
        logic signed [31:0] jac_yz;
        logic signed [31:0] jac_zz;
        logic               degenerate;
        logic               last;
    } out_t;

endpackage

// ===== design/spring_contact_force_jacobian.sv =====
// Throughput: one transaction per cycle while s_ready is high; the pipeline holds a 34-stage
// square root (one root bit per stage) feeding 50-stage dividers (one quotient bit per stage).
// An output register and a skid entry keep input flowing while one result waits;
// a full skid drops s_ready and stalls the whole pipeline.
// Reset: synchronous, active-low aresetn clears all valid bits, including the
// output and skid flags, and loads stiffness with 1.0.
`include "spring_contact_force_jacobian_defines.svh"

module spring_contact_force_jacobian (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_we,
    input  logic [31:0]    cfg_wdata,
    input  logic           s_valid,
    output logic           s_ready,
    input  scfj_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output scfj_pkg::out_t m_data
);
    import scfj_pkg::*;

    typedef struct packed {
        logic             degen;
        logic             last;
        logic [17:0]      dof;
        logic [31:0]      len0;
        logic [2:0][32:0] mag;
        logic [2:0]       neg;
    } sb1_t;

    typedef struct packed {
        logic        degen;
        logic        last;
        logic [17:0] dof;
        logic [2:0]  neg;
        logic        dneg;
    } sb2_t;

    typedef struct packed {
        logic        degen;
        logic        last;
        logic [17:0] dof;
    } tail_t;

    localparam int TAIL_N = 8;
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / MAX_NODES);
    localparam logic [DIV_W-1:0] NUM_ONE = DIV_W'(64'd1 << 32);
    localparam int RI [6] = '{0, 0, 0, 1, 1, 2};
    localparam int CI [6] = '{0, 1, 2, 1, 2, 2};

    function automatic logic [31:0] sat_q16(input logic [81:0] p, input logic neg);
        logic [65:0] v;
        logic [31:0] lim;
        logic [31:0] mv;
        v   = p[81:16];
        lim = neg ? 32'h8000_0000 : 32'h7fff_ffff;
        mv  = (v > {34'b0, lim}) ? lim : v[31:0];
        return neg ? 32'(33'd0 - {1'b0, mv}) : mv;
    endfunction

    logic        en;
    logic [31:0] k_reg;

    // stage 1
    logic signed [32:0] d1_reg [3];
    logic [31:0]        l01_reg;
    logic [15:0]        idx1_reg, q1_reg;
    logic               last1_reg, v1_reg;
    // stage 2
    logic [32:0] mag2_reg [3];
    logic [2:0]  neg2_reg;
    logic        degen2_reg, last2_reg, v2_reg;
    logic [15:0] r2_reg;
    logic [31:0] l02_reg;
    // stages 3 and 4
    logic [SUM_W-1:0] sq3_reg [3];
    logic [SUM_W-1:0] s4_reg;
    sb1_t             sd3_reg, sd4_reg;
    logic             v3_reg, v4_reg;
    // sqrt side line
    sb1_t             sb1_reg [SQRT_STAGES];
    logic             sv1_reg [SQRT_STAGES];
    logic [ROOT_W-1:0] root;
    // stage 5
    logic [DEN_W-1:0] l5_reg, l05_reg;
    logic [DIV_W-1:0] nt5_reg [3];
    logic [DIV_W-1:0] ne5_reg;
    sb2_t             s5_reg;
    logic             v5_reg;
    // divider side line
    sb2_t             sb2_reg [DIV_W];
    logic             sv2_reg [DIV_W];
    logic [DIV_W-1:0] qt [3];
    logic [DIV_W-1:0] qe, qil, qi0;
    // stages 6 to 13
    tail_t tail_reg [TAIL_N];
    logic  vt_reg   [TAIL_N];
    logic [31:0]        kt6_reg [3];
    logic [DIV_W-1:0]   eps6_reg;
    logic [32:0]        il6_reg;
    logic [16:0]        tt6_reg [6];
    logic [5:0]         ttneg6_reg, ttneg7_reg;
    logic signed [33:0] a6_reg, a7_reg, a8_reg;
    logic [2:0]         fneg6_reg, fneg7_reg, fneg8_reg;
    logic [56:0]        pflo7_reg [3];
    logic [56:0]        pfhi7_reg [3];
    logic [32:0]        part7_reg [6];
    logic [81:0]        pf8_reg [3];
    logic signed [34:0] sp8_reg [6];
    logic signed [34:0] m9_reg [6];
    logic [31:0]        fo9_reg [3];
    logic [31:0]        fo10_reg [3];
    logic [31:0]        fo11_reg [3];
    logic [31:0]        fo12_reg [3];
    logic [33:0]        mmag10_reg [6];
    logic [5:0]         mneg10_reg, mneg11_reg, mneg12_reg;
    logic [48:0]        jlo11_reg [6];
    logic [48:0]        jhi11_reg [6];
    logic [65:0]        jp12_reg [6];
    out_t               p13_reg;
    // output and skid
    logic out_v_reg, sk_v_reg;
    out_t out_d_reg, sk_d_reg;

    // combinational next values
    logic signed [32:0] d1_next [3];
    logic [47:0]        qprod_next;
    logic [32:0]        mag2_next [3];
    logic [36:0]        r2_next;
    logic [31:0]        rc3_next;
    logic [SUM_W-1:0]   sq3_next [3];
    logic               ge5_next;
    logic [32:0]        dmag5_next;
    sb1_t               sbq;
    logic [16:0]        tm [3];
    logic [48:0]        kt6_next [3];
    logic [33:0]        tt6_next [6];
    logic [49:0]        part7_next [6];
    logic [31:0]        jac13_next [6];

    assign en      = !sk_v_reg;
    assign s_ready = en;
    assign m_valid = out_v_reg;
    assign m_data  = out_d_reg;
    assign sbq     = sb1_reg[SQRT_STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= STIFF_RESET;
        end else if (cfg_we) begin
            k_reg <= cfg_wdata;
        end
    end

    always_comb begin
        d1_next[0] = $signed({s_data.node_x[31], s_data.node_x})
                   - $signed({s_data.partner_x[31], s_data.partner_x});
        d1_next[1] = $signed({s_data.node_y[31], s_data.node_y})
                   - $signed({s_data.partner_y[31], s_data.partner_y});
        d1_next[2] = $signed({s_data.node_z[31], s_data.node_z})
                   - $signed({s_data.partner_z[31], s_data.partner_z});
        qprod_next = 48'(s_data.node_index) * 48'(RECIP);
        for (int i = 0; i < 3; i++) begin
            mag2_next[i] = d1_reg[i][32] ? 33'(-d1_reg[i]) : 33'(d1_reg[i]);
            sq3_next[i]  = SUM_W'(mag2_reg[i]) * SUM_W'(mag2_reg[i]);
        end
        r2_next  = 37'(idx1_reg) - 37'(q1_reg) * 37'(MAX_NODES);
        rc3_next = (32'(r2_reg) >= 32'(MAX_NODES)) ? 32'(r2_reg) - 32'(MAX_NODES)
                                                   : 32'(r2_reg);
        ge5_next   = (root >= {1'b0, sbq.len0});
        dmag5_next = ge5_next ? root - {1'b0, sbq.len0} : {1'b0, sbq.len0} - root;
        for (int i = 0; i < 3; i++) begin
            tm[i]       = qt[i][16:0];
            kt6_next[i] = 49'(k_reg) * 49'(tm[i]);
        end
        for (int j = 0; j < 6; j++) begin
            tt6_next[j]   = 34'(tm[RI[j]]) * 34'(tm[CI[j]]);
            part7_next[j] = 50'(il6_reg) * 50'(tt6_reg[j]);
            jac13_next[j] = sat_q16(82'(jp12_reg[j]), mneg12_reg[j]);
        end
    end

    // valid bits and output handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            out_v_reg <= 1'b0;
            sk_v_reg  <= 1'b0;
            for (int i = 0; i < SQRT_STAGES; i++) sv1_reg[i] <= 1'b0;
            for (int i = 0; i < DIV_W; i++) sv2_reg[i] <= 1'b0;
            for (int i = 0; i < TAIL_N; i++) vt_reg[i] <= 1'b0;
        end else begin
            if (en) begin
                v1_reg     <= s_valid;
                v2_reg     <= v1_reg;
                v3_reg     <= v2_reg;
                v4_reg     <= v3_reg;
                sv1_reg[0] <= v4_reg;
                for (int i = 1; i < SQRT_STAGES; i++) sv1_reg[i] <= sv1_reg[i-1];
                v5_reg     <= sv1_reg[SQRT_STAGES-1];
                sv2_reg[0] <= v5_reg;
                for (int i = 1; i < DIV_W; i++) sv2_reg[i] <= sv2_reg[i-1];
                vt_reg[0]  <= sv2_reg[DIV_W-1];
                for (int i = 1; i < TAIL_N; i++) vt_reg[i] <= vt_reg[i-1];
            end
            if (sk_v_reg) begin
                if (m_ready) sk_v_reg <= 1'b0;
            end else if (vt_reg[TAIL_N-1]) begin
                if (out_v_reg && !m_ready) sk_v_reg <= 1'b1;
                else out_v_reg <= 1'b1;
            end else if (m_ready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (sk_v_reg) begin
            if (m_ready) out_d_reg <= sk_d_reg;
        end else if (vt_reg[TAIL_N-1]) begin
            if (out_v_reg && !m_ready) sk_d_reg <= p13_reg;
            else out_d_reg <= p13_reg;
        end
    end

    // datapath, advances as a whole
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) d1_reg[i] <= d1_next[i];
            l01_reg   <= (s_data.rest_length == 32'd0) ? 32'd1 : s_data.rest_length;
            idx1_reg  <= s_data.node_index;
            q1_reg    <= qprod_next[47:32];
            last1_reg <= s_data.last_contact;

            for (int i = 0; i < 3; i++) begin
                mag2_reg[i] <= mag2_next[i];
                neg2_reg[i] <= d1_reg[i][32];
            end
            degen2_reg <= (d1_reg[0] == 33'sd0) && (d1_reg[1] == 33'sd0)
                        && (d1_reg[2] == 33'sd0);
            r2_reg     <= r2_next[15:0];
            l02_reg    <= l01_reg;
            last2_reg  <= last1_reg;

            for (int i = 0; i < 3; i++) begin
                sq3_reg[i]     <= sq3_next[i];
                sd3_reg.mag[i] <= mag2_reg[i];
            end
            sd3_reg.neg   <= neg2_reg;
            sd3_reg.degen <= degen2_reg;
            sd3_reg.last  <= last2_reg;
            sd3_reg.len0  <= l02_reg;
            sd3_reg.dof   <= 18'(rc3_next * 32'(DOF_PER_NODE));

            s4_reg  <= sq3_reg[0] + sq3_reg[1] + sq3_reg[2];
            sd4_reg <= sd3_reg;

            sb1_reg[0] <= sd4_reg;
            for (int i = 1; i < SQRT_STAGES; i++) sb1_reg[i] <= sb1_reg[i-1];

            l5_reg  <= root;
            l05_reg <= {1'b0, sbq.len0};
            for (int i = 0; i < 3; i++) nt5_reg[i] <= DIV_W'({sbq.mag[i], 16'b0});
            ne5_reg      <= DIV_W'({dmag5_next, 16'b0});
            s5_reg.degen <= sbq.degen;
            s5_reg.last  <= sbq.last;
            s5_reg.dof   <= sbq.dof;
            s5_reg.neg   <= sbq.neg;
            s5_reg.dneg  <= !ge5_next;

            sb2_reg[0] <= s5_reg;
            for (int i = 1; i < DIV_W; i++) sb2_reg[i] <= sb2_reg[i-1];

            tail_reg[0].degen <= sb2_reg[DIV_W-1].degen;
            tail_reg[0].last  <= sb2_reg[DIV_W-1].last;
            tail_reg[0].dof   <= sb2_reg[DIV_W-1].dof;
            for (int i = 1; i < TAIL_N; i++) tail_reg[i] <= tail_reg[i-1];

            for (int i = 0; i < 3; i++) begin
                kt6_reg[i]   <= kt6_next[i][47:16];
                fneg6_reg[i] <= sb2_reg[DIV_W-1].neg[i] ^ sb2_reg[DIV_W-1].dneg;
            end
            for (int j = 0; j < 6; j++) begin
                tt6_reg[j]    <= tt6_next[j][32:16];
                ttneg6_reg[j] <= sb2_reg[DIV_W-1].neg[RI[j]] ^ sb2_reg[DIV_W-1].neg[CI[j]];
            end
            eps6_reg <= qe;
            il6_reg  <= qil[32:0];
            a6_reg   <= $signed({1'b0, qi0[32:0]}) - $signed({1'b0, qil[32:0]});

            for (int i = 0; i < 3; i++) begin
                pflo7_reg[i] <= 57'(kt6_reg[i]) * 57'(eps6_reg[24:0]);
                pfhi7_reg[i] <= 57'(kt6_reg[i]) * 57'(eps6_reg[49:25]);
            end
            for (int j = 0; j < 6; j++) part7_reg[j] <= part7_next[j][48:16];
            ttneg7_reg <= ttneg6_reg;
            a7_reg     <= a6_reg;
            fneg7_reg  <= fneg6_reg;

            for (int i = 0; i < 3; i++)
                pf8_reg[i] <= 82'(pflo7_reg[i]) + (82'(pfhi7_reg[i]) << 25);
            for (int j = 0; j < 6; j++)
                sp8_reg[j] <= ttneg7_reg[j] ? -$signed({2'b0, part7_reg[j]})
                                            : $signed({2'b0, part7_reg[j]});
            a8_reg    <= a7_reg;
            fneg8_reg <= fneg7_reg;

            for (int i = 0; i < 3; i++) fo9_reg[i] <= sat_q16(pf8_reg[i], fneg8_reg[i]);
            for (int j = 0; j < 6; j++)
                m9_reg[j] <= sp8_reg[j] + ((RI[j] == CI[j]) ? 35'(a8_reg) : 35'sd0);

            for (int j = 0; j < 6; j++) begin
                mneg10_reg[j] <= m9_reg[j][34];
                mmag10_reg[j] <= m9_reg[j][34] ? 34'(-m9_reg[j]) : 34'(m9_reg[j]);
            end
            for (int j = 0; j < 6; j++) begin
                jlo11_reg[j] <= 49'(k_reg) * 49'(mmag10_reg[j][16:0]);
                jhi11_reg[j] <= 49'(k_reg) * 49'(mmag10_reg[j][33:17]);
            end
            for (int j = 0; j < 6; j++)
                jp12_reg[j] <= 66'(jlo11_reg[j]) + (66'(jhi11_reg[j]) << 17);
            mneg11_reg <= mneg10_reg;
            mneg12_reg <= mneg11_reg;
            for (int i = 0; i < 3; i++) begin
                fo10_reg[i] <= fo9_reg[i];
                fo11_reg[i] <= fo10_reg[i];
                fo12_reg[i] <= fo11_reg[i];
            end

            p13_reg.dof_base   <= tail_reg[TAIL_N-2].dof;
            p13_reg.last       <= tail_reg[TAIL_N-2].last;
            p13_reg.degenerate <= tail_reg[TAIL_N-2].degen;
            if (tail_reg[TAIL_N-2].degen) begin
                p13_reg.force_x <= '0;
                p13_reg.force_y <= '0;
                p13_reg.force_z <= '0;
                p13_reg.jac_xx  <= '0;
                p13_reg.jac_xy  <= '0;
                p13_reg.jac_xz  <= '0;
                p13_reg.jac_yy  <= '0;
                p13_reg.jac_yz  <= '0;
                p13_reg.jac_zz  <= '0;
            end else begin
                p13_reg.force_x <= fo12_reg[0];
                p13_reg.force_y <= fo12_reg[1];
                p13_reg.force_z <= fo12_reg[2];
                p13_reg.jac_xx  <= jac13_next[0];
                p13_reg.jac_xy  <= jac13_next[1];
                p13_reg.jac_xz  <= jac13_next[2];
                p13_reg.jac_yy  <= jac13_next[3];
                p13_reg.jac_yz  <= jac13_next[4];
                p13_reg.jac_zz  <= jac13_next[5];
            end
        end
    end

    scfj_sqrt u_sqrt (
        .aclk     (aclk),
        .en       (en),
        .radicand (s4_reg),
        .root     (root)
    );

    for (genvar i = 0; i < 3; i++) begin : g_tdiv
        scfj_div u_div_t (
            .aclk  (aclk),
            .en    (en),
            .numer (nt5_reg[i]),
            .denom (l5_reg),
            .quot  (qt[i])
        );
    end

    scfj_div u_div_eps (
        .aclk  (aclk),
        .en    (en),
        .numer (ne5_reg),
        .denom (l05_reg),
        .quot  (qe)
    );

    scfj_div u_div_invl (
        .aclk  (aclk),
        .en    (en),
        .numer (NUM_ONE),
        .denom (l5_reg),
        .quot  (qil)
    );

    scfj_div u_div_inv0 (
        .aclk  (aclk),
        .en    (en),
        .numer (NUM_ONE),
        .denom (l05_reg),
        .quot  (qi0)
    );

    `SCFJ_ASSERT_IMPL(a_skid_implies_out, sk_v_reg, out_v_reg, "skid full with output empty")
    `SCFJ_ASSERT_NEXT(a_no_drop, (!sk_v_reg && vt_reg[TAIL_N-1] && out_v_reg && !m_ready), sk_v_reg, "result dropped on stall")
    `SCFJ_ASSERT_NEXT(a_skid_hold, (sk_v_reg && !m_ready), (sk_v_reg && $stable(sk_d_reg)), "skid changed while stalled")
    `SCFJ_ASSERT_IMPL(a_degen_zero, (m_valid && m_data.degenerate), (m_data.force_x == 32'sd0 && m_data.jac_zz == 32'sd0), "degenerate result not zero")

endmodule

// ===== design/scfj_sqrt.sv =====
module scfj_sqrt (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [scfj_pkg::SUM_W-1:0]  radicand,
    output logic [scfj_pkg::ROOT_W-1:0] root
);
    import scfj_pkg::*;

    logic [SQ_ACC_W-1:0] x_reg   [SQRT_STAGES];
    logic [SQ_ACC_W-1:0] res_reg [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        localparam logic [SQ_ACC_W-1:0] BITV =
            SQ_ACC_W'(1) << (2 * (SQRT_STAGES - 1 - k));
        logic [SQ_ACC_W-1:0] x_in;
        logic [SQ_ACC_W-1:0] res_in;
        logic [SQ_ACC_W-1:0] trial;
        logic                ge;

        if (k == 0) begin : g_first
            assign x_in   = SQ_ACC_W'(radicand);
            assign res_in = '0;
        end else begin : g_rest
            assign x_in   = x_reg[k-1];
            assign res_in = res_reg[k-1];
        end

        assign trial = res_in + BITV;
        assign ge    = (x_in >= trial);

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[k]   <= ge ? x_in - trial : x_in;
                res_reg[k] <= ge ? (res_in >> 1) + BITV : (res_in >> 1);
            end
        end
    end

    assign root = res_reg[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

// ===== design/scfj_div.sv =====
module scfj_div (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [scfj_pkg::DIV_W-1:0] numer,
    input  logic [scfj_pkg::DEN_W-1:0] denom,
    output logic [scfj_pkg::DIV_W-1:0] quot
);
    import scfj_pkg::*;

    logic [DEN_W-1:0] rem_reg [DIV_W];
    logic [DEN_W-1:0] den_reg [DIV_W];
    logic [DIV_W-1:0] num_reg [DIV_W];
    logic [DIV_W-1:0] q_reg   [DIV_W];

    for (genvar k = 0; k < DIV_W; k++) begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [DIV_W-1:0] num_in;
        logic [DIV_W-1:0] q_in;
        logic [DEN_W:0]   shifted;
        logic [DEN_W:0]   diff;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign den_in = denom;
            assign num_in = numer;
            assign q_in   = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign num_in = num_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        assign shifted = {rem_in, num_in[DIV_W-1]};
        assign diff    = shifted - {1'b0, den_in};
        assign ge      = (shifted >= {1'b0, den_in});

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
                den_reg[k] <= den_in;
                num_reg[k] <= num_in << 1;
                q_reg[k]   <= {q_in[DIV_W-2:0], ge};
            end
        end
    end

    assign quot = q_reg[DIV_W-1];

endmodule

// ===== tb/sv/tb_spring_contact_force_jacobian.sv =====
module tb_spring_contact_force_jacobian;
    timeunit 1ns;
    timeprecision 1ps;
    import scfj_pkg::*;

    localparam int LATENCY = 97;
    localparam int WATCHDOG_LIMIT = 4000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_t         s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_t        m_data;

    spring_contact_force_jacobian u_top (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    logic [31:0] stiffness = STIFF_RESET;
    in_t         contact_q[$];
    out_t        expected_q[$];
    int          errors = 0;
    int          sent = 0;
    int          received = 0;
    int          degenerate_seen = 0;
    int          saturated_seen = 0;
    int          idle_count = 0;
    bit          stim_done = 0;

    // wide helpers: 128-bit unsigned math covers every intermediate product
    function automatic logic [31:0] clamp_q16(logic [127:0] prod, bit neg);
        logic [127:0] sh;
        logic [63:0]  lim;
        logic [63:0]  lo;
        sh = prod >> 16;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        lo = sh[63:0];
        if (sh[127:64] != 0 || lo > lim) lo = lim;
        return neg ? 32'(0 - lo) : lo[31:0];
    endfunction

    function automatic logic [63:0] abs64(logic signed [63:0] v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic out_t predict_contact(in_t c, logic [31:0] k);
        out_t r;
        logic signed [63:0] d[3];
        logic signed [63:0] t[3];
        logic signed [63:0] diff, a, part, m;
        logic [127:0] sumsq, cand;
        logic [63:0] len, len0, epsmag, inv0, invl, ktmag, ttmag, tm;
        int ri[6], ci[6];
        ri = '{0, 0, 0, 1, 1, 2};
        ci = '{0, 1, 2, 1, 2, 2};
        r = '0;
        r.dof_base = 18'({2'b00, c.node_index} * DOF_PER_NODE);
        r.last = c.last_contact;
        d[0] = 64'(c.node_x) - 64'(c.partner_x);
        d[1] = 64'(c.node_y) - 64'(c.partner_y);
        d[2] = 64'(c.node_z) - 64'(c.partner_z);
        sumsq = '0;
        for (int i = 0; i < 3; i++) sumsq += 128'(abs64(d[i])) * 128'(abs64(d[i]));
        if (sumsq == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        len = '0;
        for (int b = 35; b >= 0; b--) begin
            cand = 128'(len | (64'd1 << b));
            if (cand * cand <= sumsq) len = cand[63:0];
        end
        len0 = (c.rest_length == 0) ? 64'd1 : 64'(c.rest_length);
        for (int i = 0; i < 3; i++) begin
            tm = (abs64(d[i]) << 16) / len;
            t[i] = d[i] < 0 ? -$signed(tm) : $signed(tm);
        end
        diff = $signed(len) - $signed(len0);
        epsmag = (abs64(diff) << 16) / len0;
        for (int i = 0; i < 3; i++) begin
            ktmag = (64'(k) * abs64(t[i])) >> 16;
            tm = 64'(clamp_q16(128'(ktmag) * 128'(epsmag), (t[i] < 0) != (diff < 0)));
            case (i)
                0: r.force_x = tm[31:0];
                1: r.force_y = tm[31:0];
                default: r.force_z = tm[31:0];
            endcase
        end
        inv0 = (64'd1 << 32) / len0;
        invl = (64'd1 << 32) / len;
        a = $signed(inv0) - $signed(invl);
        for (int i = 0; i < 6; i++) begin
            ttmag = (abs64(t[ri[i]]) * abs64(t[ci[i]])) >> 16;
            part = $signed(64'((128'(invl) * 128'(ttmag)) >> 16));
            m = ((t[ri[i]] < 0) != (t[ci[i]] < 0)) ? -part : part;
            if (ri[i] == ci[i]) m += a;
            tm = 64'(clamp_q16(128'(k) * 128'(abs64(m)), m < 0));
            case (i)
                0: r.jac_xx = tm[31:0];
                1: r.jac_xy = tm[31:0];
                2: r.jac_xz = tm[31:0];
                3: r.jac_yy = tm[31:0];
                4: r.jac_yz = tm[31:0];
                default: r.jac_zz = tm[31:0];
            endcase
        end
        return r;
    endfunction

    int gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_ready) begin
            // hold
        end else begin
            if (s_valid) begin
                expected_q.push_back(predict_contact(s_data, stiffness));
                sent++;
            end
            if (contact_q.size() > 0 && gap_left == 0) begin
                s_data <= contact_q.pop_front();
                s_valid <= 1'b1;
                gap_left = $urandom_range(0, 5);
            end else begin
                s_valid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end
        end
    end

    int stall_left = 0;
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            out_t exp_r;
            received++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, m_data);
            end else begin
                exp_r = expected_q.pop_front();
                if (exp_r.degenerate) degenerate_seen++;
                if (exp_r.force_x == 32'h7FFF_FFFF || exp_r.force_x == 32'h8000_0000 ||
                    exp_r.jac_xx == 32'h7FFF_FFFF || exp_r.jac_xx == 32'h8000_0000)
                    saturated_seen++;
                if (exp_r !== m_data) begin
                    errors++;
                    $display("%0t: mismatch expected %h actual %h", $time, exp_r, m_data);
                    $display("  dof %h/%h f %h %h %h / %h %h %h", exp_r.dof_base,
                             m_data.dof_base, exp_r.force_x, exp_r.force_y, exp_r.force_z,
                             m_data.force_x, m_data.force_y, m_data.force_z);
                    $display("  jac %h %h %h %h %h %h / %h %h %h %h %h %h deg %b/%b last %b/%b",
                             exp_r.jac_xx, exp_r.jac_xy, exp_r.jac_xz, exp_r.jac_yy,
                             exp_r.jac_yz, exp_r.jac_zz, m_data.jac_xx, m_data.jac_xy,
                             m_data.jac_xz, m_data.jac_yy, m_data.jac_yz, m_data.jac_zz,
                             exp_r.degenerate, m_data.degenerate, exp_r.last, m_data.last);
                end
            end
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (m_valid && m_ready) begin
            stall_left = $urandom_range(0, 5);
            m_ready <= (stall_left == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) idle_count <= 0;
        else idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, %0d results outstanding", $time, expected_q.size());
            $display("tb_spring_contact_force_jacobian: done, errors");
            $finish;
        end
    end

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
            default: return 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
        endcase
    endfunction

    function automatic in_t rand_contact();
        in_t c;
        int mode;
        mode = $urandom_range(0, 3);
        c.node_index = 16'($urandom);
        c.node_x = rand_coord(mode);
        c.node_y = rand_coord(mode);
        c.node_z = rand_coord(mode);
        if ($urandom_range(0, 19) == 0) begin
            c.partner_x = c.node_x;
            c.partner_y = c.node_y;
            c.partner_z = c.node_z;
        end else begin
            c.partner_x = rand_coord(mode);
            c.partner_y = rand_coord(mode);
            c.partner_z = rand_coord(mode);
        end
        case ($urandom_range(0, 4))
            0: c.rest_length = $urandom;
            1: c.rest_length = $urandom_range(0, 16);
            default: c.rest_length = $urandom_range(1, 32'h0100_0000);
        endcase
        c.last_contact = ($urandom_range(0, 15) == 0);
        return c;
    endfunction

    task automatic wait_drained();
        while (contact_q.size() > 0 || s_valid || expected_q.size() > 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    task automatic write_stiffness(logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        stiffness = v;
        @(posedge aclk);
    endtask

    initial begin
        in_t c;
        logic [31:0] stiff_set[5];
        stiff_set = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_0001, 32'h0040_0000};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes, coincident nodes, zero rest length, maximum node index
        c = '0;
        c.rest_length = 32'h0001_0000;
        contact_q.push_back(c);
        c.node_x = 32'h0001_0000;
        contact_q.push_back(c);
        c.rest_length = 0;
        c.node_index = 16'hFFFF;
        contact_q.push_back(c);
        c.node_x = 32'h7FFF_FFFF; c.partner_x = 32'h8000_0000;
        c.node_y = 32'h8000_0000; c.partner_y = 32'h7FFF_FFFF;
        c.node_z = 32'h7FFF_FFFF; c.partner_z = 32'h8000_0000;
        c.rest_length = 32'hFFFF_FFFF;
        contact_q.push_back(c);
        c.rest_length = 1;
        contact_q.push_back(c);
        c.last_contact = 1'b1;
        c.node_index = 16'h8000;
        c.node_x = 32'h8000_0000; c.partner_x = 32'h8000_0000;
        c.node_y = 32'h8000_0000; c.partner_y = 32'h8000_0000;
        c.node_z = 32'h8000_0000; c.partner_z = 32'h8000_0000;
        contact_q.push_back(c);
        c.node_z = 32'h8000_0001; c.rest_length = 1;
        contact_q.push_back(c);
        c.node_z = 32'hFFFF_FFFF; c.partner_z = 0; c.rest_length = 32'h0000_0100;
        contact_q.push_back(c);
        for (int i = 0; i < 8; i++) contact_q.push_back(rand_contact());
        wait_drained();

        foreach (stiff_set[p]) begin
            write_stiffness(stiff_set[p]);
            for (int i = 0; i < 330; i++) contact_q.push_back(rand_contact());
            wait_drained();
        end
        write_stiffness($urandom);
        for (int i = 0; i < 250; i++) contact_q.push_back(rand_contact());
        wait_drained();

        $display("covered %0d contacts, %0d results, %0d coincident, %0d clamped force/jac",
                 sent, received, degenerate_seen, saturated_seen);
        $display("stiffness swept over zero, one, unity, max and a random value");
        if (errors == 0) begin
            $display("tb_spring_contact_force_jacobian: done, clean");
        end else begin
            $display("tb_spring_contact_force_jacobian: done, errors");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+design
design/scfj_pkg.sv
design/scfj_sqrt.sv
design/scfj_div.sv
design/spring_contact_force_jacobian.sv
tb/sv/tb_spring_contact_force_jacobian.sv
